### sv/tdcs_pkg.sv
// tdcs_pkg: shared types, constants and width helpers for the tilted delta carriage solver.
// Used by tdcs_front, tdcs_sqrt and tilted_delta_carriage_solver_core.
package tdcs_pkg;

    localparam int DEF_COORD_WIDTH   = 24;
    localparam int DEF_DIR_FRAC_BITS = 16;

    localparam int ARM_W      = 46;
    localparam int DIR_W      = 18;
    localparam int DIRZ_W     = 17;
    localparam int CFG_DATA_W = 46;
    localparam int CFG_IDX_W  = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ARM_SQUARED = 3'd0,
        CFG_BASE_X      = 3'd1,
        CFG_BASE_Y      = 3'd2,
        CFG_DIR_X       = 3'd3,
        CFG_DIR_Y       = 3'd4,
        CFG_DIR_Z       = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic vld;
        logic unr;
    } t_ctl;

    // signed dot product width and its magnitude width
    function automatic int f_dot_w(input int cw);
        return cw + 21;
    endfunction

    function automatic int f_mag_w(input int cw);
        return cw + 20;
    endfunction

    // discriminant width, with room for the sign of the subtraction
    function automatic int f_disc_w(input int cw, input int fb);
        int m;
        int a;
        int q;
        int w;
        m = 2 * (cw + 20);
        a = ARM_W + 2 * fb;
        q = 2 * cw + 2 + 2 * fb;
        w = (m > a) ? m : a;
        w = (w > q) ? w : q;
        return w + 1;
    endfunction

    // radicand width rounded up to an even count
    function automatic int f_rad_w(input int cw, input int fb);
        return ((f_disc_w(cw, fb) + 1) >> 1) << 1;
    endfunction

endpackage

### sv/tdcs_front.sv
// tdcs_front: eight-stage front end, offsets, dot product, squares and discriminant.
// Depends on tdcs_pkg; feeds tdcs_sqrt.
module tdcs_front
    import tdcs_pkg::*;
#(
    parameter int COORD_WIDTH   = DEF_COORD_WIDTH,
    parameter int DIR_FRAC_BITS = DEF_DIR_FRAC_BITS,
    parameter int DW            = f_dot_w(COORD_WIDTH),
    parameter int XE            = f_rad_w(COORD_WIDTH, DIR_FRAC_BITS)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_vld,
    input  logic signed [COORD_WIDTH-1:0] i_pos_x,
    input  logic signed [COORD_WIDTH-1:0] i_pos_y,
    input  logic signed [COORD_WIDTH-1:0] i_pos_z,
    input  logic        [ARM_W-1:0]       i_arm_squared,
    input  logic signed [COORD_WIDTH-1:0] i_base_x,
    input  logic signed [COORD_WIDTH-1:0] i_base_y,
    input  logic signed [DIR_W-1:0]       i_dir_x,
    input  logic signed [DIR_W-1:0]       i_dir_y,
    input  logic        [DIRZ_W-1:0]      i_dir_z,
    output t_ctl                          o_ctl,
    output logic        [XE-1:0]          o_rad,
    output logic signed [DW-1:0]          o_dot
);

    localparam int CW = COORD_WIDTH;
    localparam int FB = DIR_FRAC_BITS;
    localparam int MW = f_mag_w(CW);
    localparam int HL = (MW + 1) / 2;
    localparam int HH = MW - HL;
    localparam int XW = f_disc_w(CW, FB);
    localparam int QW = 2 * CW + 2;

    logic [8:1] r_vld;

    // stage 1
    logic signed [CW:0]   r_qx, r_qy;
    logic signed [CW-1:0] r_qz;
    // stage 2
    logic signed [CW+18:0] r_px, r_py;
    logic signed [CW+17:0] r_pz;
    logic [2*CW-1:0]       r_sx, r_sy, r_sz;
    logic signed [2*CW+1:0] n_sx, n_sy;
    logic signed [2*CW-1:0] n_sz;
    // stage 3
    logic signed [DW-1:0] r_dot3;
    logic [QW-1:0]        r_qq3;
    // stage 4
    logic signed [DW-1:0] r_dot4;
    logic [MW-1:0]        r_mag;
    logic [QW-1:0]        r_qq4;
    // stage 5
    logic signed [DW-1:0] r_dot5;
    logic [2*HH-1:0]      r_hh;
    logic [HH+HL-1:0]     r_hl;
    logic [2*HL-1:0]      r_ll;
    logic [QW-1:0]        r_qq5;
    // stage 6
    logic signed [DW-1:0] r_dot6;
    logic [2*MW-1:0]      r_dsq;
    logic [QW-1:0]        r_qq6;
    // stage 7
    logic signed [DW-1:0] r_dot7;
    logic [XW-1:0]        r_pos;
    logic [XW-1:0]        r_neg;
    // stage 8
    logic signed [DW-1:0] r_dot8;
    logic [XE-1:0]        r_rad;
    logic                 r_unr;

    logic [XW:0] n_dif;

    assign n_sx  = r_qx * r_qx;
    assign n_sy  = r_qy * r_qy;
    assign n_sz  = r_qz * r_qz;
    assign n_dif = {1'b0, r_pos} - {1'b0, r_neg};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_unr <= 1'b0;
        end else if (i_en) begin
            r_vld <= {r_vld[7:1], i_vld};
            r_unr <= n_dif[XW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_qx <= (CW+1)'(i_pos_x) - (CW+1)'(i_base_x);
            r_qy <= (CW+1)'(i_pos_y) - (CW+1)'(i_base_y);
            r_qz <= i_pos_z;

            r_px <= i_dir_x * r_qx;
            r_py <= i_dir_y * r_qy;
            r_pz <= $signed({1'b0, i_dir_z}) * r_qz;
            r_sx <= n_sx[2*CW-1:0];
            r_sy <= n_sy[2*CW-1:0];
            r_sz <= n_sz;

            r_dot3 <= DW'(r_px) + DW'(r_py) + DW'(r_pz);
            r_qq3  <= QW'(r_sx) + QW'(r_sy) + QW'(r_sz);

            r_dot4 <= r_dot3;
            r_mag  <= r_dot3[DW-1] ? MW'(-r_dot3) : MW'(r_dot3);
            r_qq4  <= r_qq3;

            r_dot5 <= r_dot4;
            r_hh   <= r_mag[MW-1:HL] * r_mag[MW-1:HL];
            r_hl   <= r_mag[MW-1:HL] * r_mag[HL-1:0];
            r_ll   <= r_mag[HL-1:0] * r_mag[HL-1:0];
            r_qq5  <= r_qq4;

            r_dot6 <= r_dot5;
            r_dsq  <= ((2*MW)'(r_hh) << (2*HL)) + ((2*MW)'(r_hl) << (HL+1))
                      + (2*MW)'(r_ll);
            r_qq6  <= r_qq5;

            r_dot7 <= r_dot6;
            r_pos  <= XW'(r_dsq) + (XW'(i_arm_squared) << (2*FB));
            r_neg  <= XW'(r_qq6) << (2*FB);

            r_dot8 <= r_dot7;
            r_rad  <= n_dif[XW] ? '0 : XE'(n_dif[XW-1:0]);
        end
    end

    assign o_ctl.vld = r_vld[8];
    assign o_ctl.unr = r_unr;
    assign o_rad     = r_rad;
    assign o_dot     = r_dot8;

endmodule

### sv/tdcs_sqrt.sv
// tdcs_sqrt: pipelined integer square root, one root bit per register stage.
// Depends on tdcs_pkg; carries a side word and control alongside the radicand.
module tdcs_sqrt
    import tdcs_pkg::*;
#(
    parameter int XE = f_rad_w(DEF_COORD_WIDTH, DEF_DIR_FRAC_BITS),
    parameter int SW = f_dot_w(DEF_COORD_WIDTH)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  t_ctl              i_ctl,
    input  logic [XE-1:0]     i_rad,
    input  logic [SW-1:0]     i_side,
    output t_ctl              o_ctl,
    output logic [XE/2-1:0]   o_root,
    output logic [SW-1:0]     o_side
);

    localparam int RW = XE / 2;

    t_ctl             r_ctl  [RW];
    logic [RW+1:0]    r_rem  [RW];
    logic [RW-1:0]    r_root [RW];
    logic [XE-1:0]    r_rad  [RW];
    logic [SW-1:0]    r_side [RW];

    for (genvar g = 0; g < RW; g++) begin : g_stage
        t_ctl          ctl_in;
        logic [RW+1:0] rem_in;
        logic [RW-1:0] root_in;
        logic [XE-1:0] rad_in;
        logic [SW-1:0] side_in;
        logic [RW+3:0] rem_sh;
        logic [RW+3:0] trial;
        logic [RW+3:0] diff;
        logic          ge;

        if (g == 0) begin : g_head
            assign ctl_in  = i_ctl;
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = i_rad;
            assign side_in = i_side;
        end else begin : g_body
            assign ctl_in  = r_ctl[g-1];
            assign rem_in  = r_rem[g-1];
            assign root_in = r_root[g-1];
            assign rad_in  = r_rad[g-1];
            assign side_in = r_side[g-1];
        end

        assign rem_sh = {rem_in, rad_in[XE-1 -: 2]};
        assign trial  = {2'b00, root_in, 2'b01};
        assign ge     = (rem_sh >= trial);
        assign diff   = rem_sh - trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[g] <= '0;
            end else if (i_en) begin
                r_ctl[g] <= ctl_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g]  <= ge ? diff[RW+1:0] : rem_sh[RW+1:0];
                r_root[g] <= {root_in[RW-2:0], ge};
                r_rad[g]  <= {rad_in[XE-3:0], 2'b00};
                r_side[g] <= side_in;
            end
        end
    end

    assign o_ctl  = r_ctl[RW-1];
    assign o_root = r_root[RW-1];
    assign o_side = r_side[RW-1];

endmodule

### sv/tilted_delta_carriage_solver_core.sv
// Carriage solver top level: configuration registers, front end, square root, round and clamp.
// Depends on tdcs_pkg, tdcs_front and tdcs_sqrt.
//
// Usage: one toolhead position (i_pos_x/y/z) is taken per beat on the input channel
// (i_valid / o_ready) and one carriage position with its unreachable flag is given per
// beat on the output channel (o_valid / i_ready), in order.
// Throughput: one beat per cycle while the receiver keeps i_ready high.
// Pipeline: front end, square root, round and output registers; RW is half the radicand
// width (45 at the default widths) and the square root takes one bit per stage.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx at once; write only
// while no beat is in flight. Indexes past the last register are ignored.
// Reset: synchronous on i_rst_n low; all valid bits clear, the direction resets to an
// upright tower and the other configuration registers to zero.
// Stall: when the output holds a beat and i_ready is low, the whole pipeline freezes and
// o_ready drops; nothing is lost or repeated. Bubbles in the pipeline do not stall it.
module tilted_delta_carriage_solver_core
    import tdcs_pkg::*;
#(
    parameter int COORD_WIDTH   = DEF_COORD_WIDTH,
    parameter int DIR_FRAC_BITS = DEF_DIR_FRAC_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [COORD_WIDTH-1:0] i_pos_x,
    input  logic signed [COORD_WIDTH-1:0] i_pos_y,
    input  logic signed [COORD_WIDTH-1:0] i_pos_z,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [COORD_WIDTH:0]   o_carriage_pos,
    output logic                          o_unreachable
);

    localparam int CW  = COORD_WIDTH;
    localparam int FB  = DIR_FRAC_BITS;
    localparam int OW  = CW + 1;
    localparam int DW  = f_dot_w(CW);
    localparam int XE  = f_rad_w(CW, FB);
    localparam int RW  = XE / 2;
    localparam int VW  = ((DW > RW + 1) ? DW : RW + 1) + 2;
    localparam logic [VW-1:0] HALF = VW'(1) << (FB - 1);
    localparam logic signed [VW-1:0] OMAX = {{(VW-OW+1){1'b0}}, {(OW-1){1'b1}}};
    localparam logic signed [VW-1:0] OMIN = {{(VW-OW+1){1'b1}}, {(OW-1){1'b0}}};

    logic [ARM_W-1:0]        r_arm_squared;
    logic signed [CW-1:0]    r_base_x, r_base_y;
    logic signed [DIR_W-1:0] r_dir_x, r_dir_y;
    logic [DIRZ_W-1:0]       r_dir_z;

    logic en;

    t_ctl                 fr_ctl, sq_ctl;
    logic [XE-1:0]        fr_rad;
    logic signed [DW-1:0] fr_dot;
    logic [DW-1:0]        sq_side;
    logic [RW-1:0]        sq_root;

    logic                 r_v_vld, r_v_unr;
    logic signed [VW-1:0] r_v;
    logic signed [VW-1:0] n_r;

    logic                 r_out_vld;
    logic signed [OW-1:0] r_out_pos;
    logic                 r_out_unr;

    assign en      = !r_out_vld || i_ready;
    assign o_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arm_squared <= '0;
            r_base_x      <= '0;
            r_base_y      <= '0;
            r_dir_x       <= '0;
            r_dir_y       <= '0;
            r_dir_z       <= DIRZ_W'(1) << FB;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_ARM_SQUARED: r_arm_squared <= i_cfg_data[ARM_W-1:0];
                CFG_BASE_X:      r_base_x      <= i_cfg_data[CW-1:0];
                CFG_BASE_Y:      r_base_y      <= i_cfg_data[CW-1:0];
                CFG_DIR_X:       r_dir_x       <= i_cfg_data[DIR_W-1:0];
                CFG_DIR_Y:       r_dir_y       <= i_cfg_data[DIR_W-1:0];
                CFG_DIR_Z:       r_dir_z       <= i_cfg_data[DIRZ_W-1:0];
                default: begin
                end
            endcase
        end
    end

    tdcs_front #(
        .COORD_WIDTH   (CW),
        .DIR_FRAC_BITS (FB),
        .DW            (DW),
        .XE            (XE)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (en),
        .i_vld         (i_valid),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_pos_z       (i_pos_z),
        .i_arm_squared (r_arm_squared),
        .i_base_x      (r_base_x),
        .i_base_y      (r_base_y),
        .i_dir_x       (r_dir_x),
        .i_dir_y       (r_dir_y),
        .i_dir_z       (r_dir_z),
        .o_ctl         (fr_ctl),
        .o_rad         (fr_rad),
        .o_dot         (fr_dot)
    );

    tdcs_sqrt #(
        .XE (XE),
        .SW (DW)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (fr_ctl),
        .i_rad   (fr_rad),
        .i_side  (fr_dot),
        .o_ctl   (sq_ctl),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    // dot + root + half, then floor by the fraction width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_vld <= 1'b0;
        end else if (en) begin
            r_v_vld <= sq_ctl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_v_unr <= sq_ctl.unr;
            r_v     <= VW'($signed(sq_side)) + VW'(sq_root) + HALF;
        end
    end

    assign n_r = r_v >>> FB;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_v_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_unr <= r_v_unr;
            priority if (r_v_unr) begin
                r_out_pos <= '0;
            end else if (n_r > OMAX) begin
                r_out_pos <= OMAX[OW-1:0];
            end else if (n_r < OMIN) begin
                r_out_pos <= OMIN[OW-1:0];
            end else begin
                r_out_pos <= n_r[OW-1:0];
            end
        end
    end

    assign o_valid        = r_out_vld;
    assign o_carriage_pos = r_out_pos;
    assign o_unreachable  = r_out_unr;

endmodule
